// File: hdl/fbpm_pkg.sv
// shared constants, types and helpers of the frame buffer pool manager
package fbpm_pkg;

    localparam int NUM_BUFFERS = 3;
    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    localparam int REQ_W = 3;
    localparam int BIDX_W = 3;
    localparam int TIME_W = 64;
    localparam int CNT_W = 32;
    localparam int PERIOD_CFG_W = 20;
    localparam int TIMEOUT_W = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [IDX_W-1:0] slot_idx_t;
    typedef logic [1:0] status_t;
    typedef logic [REQ_W-1:0] req_code_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam status_t ST_FREE = 2'd0;
    localparam status_t ST_FILLING = 2'd1;
    localparam status_t ST_READY = 2'd2;
    localparam status_t ST_IN_USE = 2'd3;

    localparam req_code_t REQ_FRAME_DONE = 3'd0;
    localparam req_code_t REQ_ACQ_DISPLAY = 3'd1;
    localparam req_code_t REQ_ACQ_SECOND = 3'd2;
    localparam req_code_t REQ_REL_DISPLAY = 3'd3;
    localparam req_code_t REQ_REL_SECOND = 3'd4;
    localparam req_code_t REQ_STATUS = 3'd5;

    localparam cfg_idx_t CFG_MIN_PERIOD = 2'd0;
    localparam cfg_idx_t CFG_MAX_PERIOD = 2'd1;
    localparam cfg_idx_t CFG_LOSS_TIMEOUT = 2'd2;

    localparam logic [PERIOD_CFG_W-1:0] MIN_PERIOD_RST = 20'd19000;
    localparam logic [PERIOD_CFG_W-1:0] MAX_PERIOD_RST = 20'd21200;
    localparam logic [TIMEOUT_W-1:0] LOSS_TIMEOUT_RST = 24'd100000;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [BIDX_W-1:0] slot_sel;
        logic [TIME_W-1:0] now_us;
    } req_t;

    typedef struct packed {
        logic granted;
        logic [BIDX_W-1:0] granted_index;
        logic [CNT_W-1:0] granted_sequence;
        logic [BIDX_W-1:0] fill_target;
        logic no_free_buffer;
        logic [CNT_W-1:0] frames_done;
        logic [CNT_W-1:0] stale_count;
        logic [CNT_W-1:0] period_us;
        logic lock_ok;
    } res_t;

    typedef struct packed {
        logic [PERIOD_CFG_W-1:0] min_period;
        logic [PERIOD_CFG_W-1:0] max_period;
        logic [TIMEOUT_W-1:0] loss_timeout;
    } cfg_t;

    // wrapping sequence compare: a newer than b
    function automatic logic seq_newer(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] b);
        logic [CNT_W-1:0] d;
        d = a - b;
        return (d != '0) && !d[CNT_W-1];
    endfunction

endpackage

// File: hdl/fbpm_if.sv
// handshake channels of the frame buffer pool manager
interface fbpm_req_if;
    logic valid;
    logic ready;
    logic [fbpm_pkg::REQ_W-1:0] req_type;
    logic [fbpm_pkg::BIDX_W-1:0] slot_sel;
    logic [fbpm_pkg::TIME_W-1:0] now_us;

    modport source (output valid, output req_type, output slot_sel, output now_us,
                    input ready);
    modport sink (input valid, input req_type, input slot_sel, input now_us,
                  output ready);
endinterface

interface fbpm_res_if;
    logic valid;
    logic ready;
    logic granted;
    logic [fbpm_pkg::BIDX_W-1:0] granted_index;
    logic [fbpm_pkg::CNT_W-1:0] granted_sequence;
    logic [fbpm_pkg::BIDX_W-1:0] fill_target;
    logic no_free_buffer;
    logic [fbpm_pkg::CNT_W-1:0] frames_done;
    logic [fbpm_pkg::CNT_W-1:0] stale_count;
    logic [fbpm_pkg::CNT_W-1:0] period_us;
    logic lock_ok;

    modport source (output valid, output granted, output granted_index,
                    output granted_sequence, output fill_target, output no_free_buffer,
                    output frames_done, output stale_count, output period_us,
                    output lock_ok, input ready);
    modport sink (input valid, input granted, input granted_index,
                  input granted_sequence, input fill_target, input no_free_buffer,
                  input frames_done, input stale_count, input period_us,
                  input lock_ok, output ready);
endinterface

interface fbpm_cfg_if;
    logic valid;
    logic ready;
    logic [fbpm_pkg::CFG_IDX_W-1:0] index;
    logic [fbpm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/fbpm_cfg_regs.sv
// configuration registers: period limits and loss timeout
module fbpm_cfg_regs (
    input  logic clk,
    input  logic rst_n,
    fbpm_cfg_if.sink cfg,
    output fbpm_pkg::cfg_t cfg_val
);
    import fbpm_pkg::*;

    logic [PERIOD_CFG_W-1:0] min_period_reg;
    logic [PERIOD_CFG_W-1:0] max_period_reg;
    logic [TIMEOUT_W-1:0] loss_timeout_reg;
    logic wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
            loss_timeout_reg <= LOSS_TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            unique case (cfg.index)
                CFG_MIN_PERIOD: min_period_reg <= cfg.data[PERIOD_CFG_W-1:0];
                CFG_MAX_PERIOD: max_period_reg <= cfg.data[PERIOD_CFG_W-1:0];
                CFG_LOSS_TIMEOUT: loss_timeout_reg <= cfg.data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg_val.min_period = min_period_reg;
    assign cfg_val.max_period = max_period_reg;
    assign cfg_val.loss_timeout = loss_timeout_reg;
endmodule

// File: hdl/fbpm_pool.sv
// buffer pool state and the single-pass update for one item
module fbpm_pool (
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  fbpm_pkg::req_t item,
    input  fbpm_pkg::cfg_t cfg_val,
    output fbpm_pkg::res_t result
);
    import fbpm_pkg::*;

    status_t status_reg [NUM_BUFFERS];
    status_t status_next [NUM_BUFFERS];
    logic [NUM_BUFFERS-1:0] hold_reg;
    logic [NUM_BUFFERS-1:0] hold_next;
    logic [CNT_W-1:0] seq_reg [NUM_BUFFERS];
    logic [CNT_W-1:0] seq_next [NUM_BUFFERS];
    slot_idx_t fill_reg;
    slot_idx_t fill_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] replaced_reg;
    logic [CNT_W-1:0] replaced_next;
    logic [CNT_W-1:0] period_reg;
    logic [CNT_W-1:0] period_next;
    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;

    always_comb
    begin
        logic free_found;
        slot_idx_t free_idx;
        logic rdy_found;
        slot_idx_t rdy_idx;
        logic [CNT_W-1:0] best_age;
        logic [CNT_W-1:0] age;
        logic acq_found;
        slot_idx_t acq_idx;
        logic [CNT_W-1:0] acq_seq;
        logic ok;
        slot_idx_t rel_idx;
        logic rel_ok;
        logic nofree;
        logic [TIME_W-1:0] elapsed;

        status_next = status_reg;
        hold_next = hold_reg;
        seq_next = seq_reg;
        fill_next = fill_reg;
        count_next = count_reg;
        replaced_next = replaced_reg;
        period_next = period_reg;
        time_next = time_reg;
        free_found = 1'b0;
        free_idx = '0;
        rdy_found = 1'b0;
        rdy_idx = '0;
        best_age = '0;
        age = '0;
        acq_found = 1'b0;
        acq_idx = '0;
        acq_seq = '0;
        ok = 1'b0;
        nofree = 1'b0;
        rel_idx = item.slot_sel[IDX_W-1:0];
        rel_ok = ({1'b0, item.slot_sel} < (BIDX_W+1)'(NUM_BUFFERS));

        unique case (item.req_type)
            REQ_FRAME_DONE:
            begin
                if (time_reg != '0)
                begin
                    period_next = CNT_W'(item.now_us - time_reg);
                end
                time_next = item.now_us;
                count_next = count_reg + 1'b1;
                seq_next[fill_reg] = count_next;
                status_next[fill_reg] = ST_READY;
                for (int i = 0; i < NUM_BUFFERS; i++)
                begin
                    if (!free_found && status_next[i] == ST_FREE && !hold_reg[i])
                    begin
                        free_found = 1'b1;
                        free_idx = IDX_W'(i);
                    end
                end
                for (int i = 0; i < NUM_BUFFERS; i++)
                begin
                    age = count_next - seq_next[i];
                    if (status_next[i] == ST_READY && !hold_reg[i] &&
                        (!rdy_found || age > best_age))
                    begin
                        rdy_found = 1'b1;
                        rdy_idx = IDX_W'(i);
                        best_age = age;
                    end
                end
                if (free_found)
                begin
                    fill_next = free_idx;
                end
                else if (rdy_found)
                begin
                    fill_next = rdy_idx;
                    replaced_next = replaced_reg + 1'b1;
                end
                else
                begin
                    nofree = 1'b1;
                    fill_next = fill_reg;
                end
                status_next[fill_next] = ST_FILLING;
            end
            REQ_ACQ_DISPLAY, REQ_ACQ_SECOND:
            begin
                for (int i = 0; i < NUM_BUFFERS; i++)
                begin
                    if (item.req_type == REQ_ACQ_DISPLAY)
                    begin
                        ok = (status_reg[i] == ST_READY);
                    end
                    else
                    begin
                        ok = (status_reg[i] == ST_READY || status_reg[i] == ST_IN_USE) &&
                             !hold_reg[i];
                    end
                    if (ok && (!acq_found || seq_newer(seq_reg[i], acq_seq)))
                    begin
                        acq_found = 1'b1;
                        acq_idx = IDX_W'(i);
                        acq_seq = seq_reg[i];
                    end
                end
                if (acq_found)
                begin
                    if (item.req_type == REQ_ACQ_DISPLAY)
                    begin
                        status_next[acq_idx] = ST_IN_USE;
                    end
                    else
                    begin
                        hold_next[acq_idx] = 1'b1;
                    end
                end
            end
            REQ_REL_DISPLAY:
            begin
                if (rel_ok && status_reg[rel_idx] == ST_IN_USE)
                begin
                    status_next[rel_idx] = ST_FREE;
                end
            end
            REQ_REL_SECOND:
            begin
                if (rel_ok)
                begin
                    hold_next[rel_idx] = 1'b0;
                end
            end
            default: ;
        endcase

        elapsed = item.now_us - time_next;

        result.granted = acq_found;
        result.granted_index = acq_found ? BIDX_W'(acq_idx) : '0;
        result.granted_sequence = acq_found ? acq_seq : '0;
        result.fill_target = BIDX_W'(fill_next);
        result.no_free_buffer = nofree;
        result.frames_done = count_next;
        result.stale_count = replaced_next;
        result.period_us = period_next;
        result.lock_ok = (time_next != '0) &&
                         (period_next >= CNT_W'(cfg_val.min_period)) &&
                         (period_next <= CNT_W'(cfg_val.max_period)) &&
                         (elapsed <= TIME_W'(cfg_val.loss_timeout));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUFFERS; i++)
            begin
                status_reg[i] <= (i == 0) ? ST_FILLING : ST_FREE;
                seq_reg[i] <= '0;
            end
            hold_reg <= '0;
            fill_reg <= '0;
            count_reg <= '0;
            replaced_reg <= '0;
            period_reg <= '0;
            time_reg <= '0;
        end
        else if (step_en)
        begin
            status_reg <= status_next;
            seq_reg <= seq_next;
            hold_reg <= hold_next;
            fill_reg <= fill_next;
            count_reg <= count_next;
            replaced_reg <= replaced_next;
            period_reg <= period_next;
            time_reg <= time_next;
        end
    end
endmodule

// File: hdl/frame_buffer_pool_manager.sv
// frame buffer pool manager top level: input register, pool update, result register
// path: an accepted item is held in the input register, passes the pool update, then is held in the result register
// throughput: one item per cycle while the result is not stalled; the pool state updates once per item in a single pass
// a stalled result holds the result register, then the input register, then req.ready
// reset: slot 0 filling, other slots free, all counters, period and frame time zero
// reset: period limits and loss timeout return to their default values
module frame_buffer_pool_manager (
    input  logic clk,
    input  logic rst_n,
    fbpm_req_if.sink req,
    fbpm_res_if.source res,
    fbpm_cfg_if.sink cfg
);
    import fbpm_pkg::*;

    req_t in_data_reg;
    logic in_valid_reg;
    logic in_valid_next;
    res_t out_data_reg;
    logic out_valid_reg;
    logic out_valid_next;
    logic advance;
    logic step_en;
    logic req_fire;
    req_t req_data;
    res_t result;
    cfg_t cfg_val;

    fbpm_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    fbpm_pool u_pool (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_data_reg),
        .cfg_val (cfg_val),
        .result  (result)
    );

    assign advance = !out_valid_reg || res.ready;
    assign step_en = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;
    assign req_fire = req.valid && req.ready;
    assign in_valid_next = req_fire || (in_valid_reg && !advance);
    assign out_valid_next = step_en || (out_valid_reg && !res.ready);

    assign req_data.req_type = req.req_type;
    assign req_data.slot_sel = req.slot_sel;
    assign req_data.now_us = req.now_us;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            in_data_reg <= req_data;
        end
        if (step_en)
        begin
            out_data_reg <= result;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.granted = out_data_reg.granted;
    assign res.granted_index = out_data_reg.granted_index;
    assign res.granted_sequence = out_data_reg.granted_sequence;
    assign res.fill_target = out_data_reg.fill_target;
    assign res.no_free_buffer = out_data_reg.no_free_buffer;
    assign res.frames_done = out_data_reg.frames_done;
    assign res.stale_count = out_data_reg.stale_count;
    assign res.period_us = out_data_reg.period_us;
    assign res.lock_ok = out_data_reg.lock_ok;
endmodule
